@@ hw/rtl/fd_pkg.sv @@
// Shared types and constants for the frame deframer.
package fd_pkg;

  localparam int unsigned HEADER_WORDS = 5;
  localparam int unsigned HDR_BYTES    = HEADER_WORDS * 4;
  localparam int unsigned POS_W        = 25;
  localparam int unsigned IDX_W        = 24;

  localparam logic [31:0] PACKET_CHANNEL = 32'hFFFF_FFFF;
  localparam logic [23:0] RESET_MAX_LEN  = 24'(1024 * 500);
  localparam logic [7:0]  RESET_MAX_SEEK = 8'd3;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LENGTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEEK_MODE    = 8'd1;

  localparam int unsigned TDATA_W = 136;
  localparam int unsigned TUSER_W = 3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_BAD_SEEK  = 2'd2
  } status_t;

  typedef struct packed {
    logic [23:0] max_frame_length;
    logic [7:0]  max_seek_mode;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]   payload_index;
    logic [7:0]         seek_code;
    logic signed [63:0] stream_offset;
    logic [31:0]        channel;
    logic [7:0]         payload_byte;
    logic               is_packet;
    logic               frame_last;
    status_t            status;
  } result_t;

endpackage

@@ hw/rtl/fd_cfg.sv @@
// Configuration registers of the frame deframer.
module fd_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output fd_pkg::cfg_t                    cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_frame_length <= fd_pkg::RESET_MAX_LEN;
      cfg.max_seek_mode    <= fd_pkg::RESET_MAX_SEEK;
    end else if (cfg_valid) begin
      if (cfg_index == fd_pkg::CFG_MAX_FRAME_LENGTH) begin
        cfg.max_frame_length <= cfg_data[23:0];
      end
      if (cfg_index == fd_pkg::CFG_MAX_SEEK_MODE) begin
        cfg.max_seek_mode <= cfg_data[7:0];
      end
    end
  end

endmodule

@@ hw/rtl/fd_parse.sv @@
// Descriptor parser and payload tagger: frame state plus the single-pass result logic.
module fd_parse (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      rx_byte,
  input  fd_pkg::cfg_t    cfg,
  output logic            res_valid,
  output fd_pkg::result_t res
);

  logic [fd_pkg::POS_W-1:0] byte_position, byte_position_next;
  logic [31:0] frame_length, frame_length_next;
  logic [31:0] frame_channel, frame_channel_next;
  logic [63:0] frame_offset, frame_offset_next;
  logic [31:0] frame_seek, frame_seek_next;
  logic        seek_info_used, seek_info_used_next;
  logic        stream_dead, stream_dead_next;

  logic                     in_header;
  logic [2:0]               word;
  logic [fd_pkg::POS_W-1:0] pos_inc;
  logic [fd_pkg::POS_W-1:0] idx;
  logic [31:0]              idx_p1;
  logic [31:0]              seek_full;
  logic                     is_pkt;
  logic                     last;
  logic                     first;

  assign in_header = byte_position < fd_pkg::POS_W'(fd_pkg::HDR_BYTES);
  assign word      = byte_position[4:2];
  assign pos_inc   = byte_position + fd_pkg::POS_W'(1);
  assign idx       = byte_position - fd_pkg::POS_W'(fd_pkg::HDR_BYTES);
  assign idx_p1    = 32'(idx) + 32'd1;
  // The seek word completes with the last descriptor byte itself.
  assign seek_full = {frame_seek[23:0], rx_byte};
  assign is_pkt    = frame_channel == fd_pkg::PACKET_CHANNEL;
  assign last      = idx_p1 >= frame_length;
  assign first     = !seek_info_used && !is_pkt;

  always_comb begin
    byte_position_next  = byte_position;
    frame_length_next   = frame_length;
    frame_channel_next  = frame_channel;
    frame_offset_next   = frame_offset;
    frame_seek_next     = frame_seek;
    seek_info_used_next = seek_info_used;
    stream_dead_next    = stream_dead;
    res_valid           = 1'b0;
    res                 = '0;
    res.status          = fd_pkg::ST_OK;

    if (step && !stream_dead) begin
      if (in_header) begin
        unique case (word)
          3'd0:        frame_length_next  = {frame_length[23:0], rx_byte};
          3'd1:        frame_channel_next = {frame_channel[23:0], rx_byte};
          3'd2, 3'd3:  frame_offset_next  = {frame_offset[55:0], rx_byte};
          3'd4:        frame_seek_next    = seek_full;
          default:     ;
        endcase
        byte_position_next = pos_inc;
        if (pos_inc == fd_pkg::POS_W'(fd_pkg::HDR_BYTES)) begin
          seek_info_used_next = 1'b0;
          priority if (frame_length > 32'(cfg.max_frame_length)) begin
            stream_dead_next = 1'b1;
            res_valid        = 1'b1;
            res.status       = fd_pkg::ST_TOO_LARGE;
          end else if (!is_pkt && seek_full > 32'(cfg.max_seek_mode)) begin
            stream_dead_next = 1'b1;
            res_valid        = 1'b1;
            res.status       = fd_pkg::ST_BAD_SEEK;
          end else if (frame_length == 32'd0) begin
            byte_position_next = '0;
          end else begin
            byte_position_next = pos_inc;
          end
        end
      end else begin
        res_valid         = 1'b1;
        res.payload_byte  = rx_byte;
        res.is_packet     = is_pkt;
        res.channel       = frame_channel;
        res.stream_offset = first ? frame_offset : 64'd0;
        res.seek_code     = first ? frame_seek[7:0] : 8'd0;
        res.payload_index = idx[fd_pkg::IDX_W-1:0];
        res.frame_last    = last;
        seek_info_used_next = 1'b1;
        byte_position_next  = last ? '0 : pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      frame_length   <= '0;
      frame_channel  <= '0;
      frame_offset   <= '0;
      frame_seek     <= '0;
      seek_info_used <= 1'b0;
      stream_dead    <= 1'b0;
    end else begin
      byte_position  <= byte_position_next;
      frame_length   <= frame_length_next;
      frame_channel  <= frame_channel_next;
      frame_offset   <= frame_offset_next;
      frame_seek     <= frame_seek_next;
      seek_info_used <= seek_info_used_next;
      stream_dead    <= stream_dead_next;
    end
  end

endmodule

@@ hw/rtl/frame_deframer_unit.sv @@
// Frame deframer top level: input register, parser and result register.
// Each byte passes the input register and then the result register before its result is on m_tvalid.
// Throughput: one byte per cycle while results are taken; the parser state loop is closed through its registers.
// A waiting result stops input transfers once the input register holds a byte;
// with m_tready high, bytes follow back to back.
// Reset clears the frame state and sets the limits to 512000 bytes and seek mode 3.
module frame_deframer_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // [7:0] rx_byte
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [7:0] payload_byte, [39:8] channel, [103:40] stream_offset,
  // [111:104] seek_code, [135:112] payload_index
  output logic [fd_pkg::TDATA_W-1:0]         m_tdata,
  output logic [fd_pkg::TUSER_W-1:0]         m_tuser,   // [0] is_packet, [2:1] status
  output logic                               m_tlast,   // frame_last
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  fd_pkg::cfg_t    cfg;
  fd_pkg::result_t res;
  fd_pkg::result_t out_res;
  logic            res_valid;
  logic            in_valid;
  logic [7:0]      in_byte;
  logic            advance;

  fd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held byte moves through the parser when the result register is free or emptying.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  fd_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .rx_byte   (in_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {out_res.payload_index, out_res.seek_code, out_res.stream_offset,
                    out_res.channel, out_res.payload_byte};
  assign m_tuser = {out_res.status, out_res.is_packet};
  assign m_tlast = out_res.frame_last;

endmodule

@@ hw/rtl/fd_checker.sv @@
// Port-level checker for the frame deframer, bound to the top level.
module fd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [fd_pkg::TDATA_W-1:0]    m_tdata,
  input logic [fd_pkg::TUSER_W-1:0]    m_tuser,
  input logic                          m_tlast
);

  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // After an error transfer the stream is dead and nothing more comes out.
  a_dead: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser[2:1] != 2'd0 |=> !m_tvalid)
    else $error("result after error");

  // Error results carry only the status.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2:1] != 2'd0 |-> m_tdata == '0 && !m_tlast && !m_tuser[0])
    else $error("error result carries payload fields");

  // Packet frames never carry offset or seek mode.
  a_pkt_noseek: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[111:40] == '0 && m_tuser[2:1] == 2'd0)
    else $error("packet result carries seek information");

endmodule

bind frame_deframer_unit fd_checker u_fd_checker (.*);

@@ verif/tb_top.sv @@
// Self-checking testbench for the frame deframer: framed byte stream in, tagged payload out.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned RANDOM_BYTES  = 90;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 16;
  localparam logic [fd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 8'hA7;
  localparam logic [23:0] LEN_LIMIT_MAX  = 24'hFF_FFFF;
  localparam logic [7:0]  SEEK_LIMIT_MAX = 8'hFF;

  // Word numbers within the descriptor.
  localparam int W_LENGTH    = 0;
  localparam int W_CHANNEL   = 1;
  localparam int W_OFFSET_HI = 2;
  localparam int W_OFFSET_LO = 3;
  localparam int W_SEEK      = 4;

  logic                          clk;
  logic                          rst       = 1'b1;
  logic                          s_tvalid  = 1'b0;
  logic                          s_tready;
  logic [7:0]                    s_tdata   = '0;
  logic                          m_tvalid;
  logic                          m_tready  = 1'b0;
  logic [fd_pkg::TDATA_W-1:0]    m_tdata;
  logic [fd_pkg::TUSER_W-1:0]    m_tuser;
  logic                          m_tlast;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [fd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [fd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  frame_deframer_unit i_dut (.*);

  // Predicted state of the parser and its limits.
  logic [fd_pkg::POS_W-1:0] rx_pos;
  logic [31:0]      desc_len;
  logic [31:0]      desc_chan;
  logic [63:0]      desc_off;
  logic [31:0]      desc_seek;
  logic             offset_given;
  logic             link_dead;
  logic [23:0]      lim_len;
  logic [7:0]       lim_seek;

  fd_pkg::result_t expected_out[$];
  int unsigned mismatches  = 0;
  int unsigned cycles      = 0;
  int unsigned bytes_sent  = 0;
  int unsigned stall_left  = 0;
  bit          src_gaps    = 1'b0;
  bit          sink_stalls = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 99) < 25) begin
      stall_left <= pick_gap();
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic reset_model();
    rx_pos       = '0;
    desc_len     = '0;
    desc_chan    = '0;
    desc_off     = '0;
    desc_seek    = '0;
    offset_given = 1'b0;
    link_dead    = 1'b0;
    lim_len      = fd_pkg::RESET_MAX_LEN;
    lim_seek     = fd_pkg::RESET_MAX_SEEK;
  endtask

  // Works out what one received byte produces and queues it.
  task automatic model_rx_byte(input logic [7:0] b);
    fd_pkg::result_t r;
    logic [31:0] idx;
    logic        pkt;
    logic        last;
    if (link_dead) return;
    r = '0;
    if (rx_pos < fd_pkg::HDR_BYTES) begin
      case (rx_pos >> 2)
        W_LENGTH:                 desc_len  = {desc_len[23:0], b};
        W_CHANNEL:                desc_chan = {desc_chan[23:0], b};
        W_OFFSET_HI, W_OFFSET_LO: desc_off  = {desc_off[55:0], b};
        W_SEEK:                   desc_seek = {desc_seek[23:0], b};
        default: ;
      endcase
      rx_pos = rx_pos + fd_pkg::POS_W'(1);
      if (rx_pos == fd_pkg::HDR_BYTES) begin
        offset_given = 1'b0;
        if (desc_len > {8'h00, lim_len}) begin
          link_dead = 1'b1;
          r.status  = fd_pkg::ST_TOO_LARGE;
          expected_out.push_back(r);
        end else if (desc_chan != fd_pkg::PACKET_CHANNEL &&
                     desc_seek > {24'h0, lim_seek}) begin
          link_dead = 1'b1;
          r.status  = fd_pkg::ST_BAD_SEEK;
          expected_out.push_back(r);
        end else if (desc_len == 0) begin
          rx_pos = '0;
        end
      end
      return;
    end
    idx  = 32'(rx_pos) - fd_pkg::HDR_BYTES;
    pkt  = (desc_chan == fd_pkg::PACKET_CHANNEL);
    last = (idx + 32'd1 >= desc_len);
    r.payload_index = idx[fd_pkg::IDX_W-1:0];
    r.payload_byte  = b;
    r.is_packet     = pkt;
    r.channel       = desc_chan;
    r.frame_last    = last;
    r.status        = fd_pkg::ST_OK;
    if (!offset_given && !pkt) begin
      r.stream_offset = desc_off;
      r.seek_code     = desc_seek[7:0];
    end
    offset_given = 1'b1;
    rx_pos = last ? '0 : rx_pos + fd_pkg::POS_W'(1);
    expected_out.push_back(r);
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    fd_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_out.size() == 0) begin
        $error("result with nothing expected: tdata %0h tuser %0h", m_tdata, m_tuser);
        mismatches++;
      end else begin
        want = expected_out.pop_front();
        check_field("payload_byte", want.payload_byte, m_tdata[7:0]);
        check_field("channel", want.channel, m_tdata[39:8]);
        check_field("stream_offset", want.stream_offset, m_tdata[103:40]);
        check_field("seek_code", want.seek_code, m_tdata[111:104]);
        check_field("payload_index", want.payload_index, m_tdata[135:112]);
        check_field("is_packet", want.is_packet, m_tuser[0]);
        check_field("status", want.status, m_tuser[2:1]);
        check_field("frame_last", want.frame_last, m_tlast);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    model_rx_byte(b);
    bytes_sent++;
    gap = (src_gaps && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the input back until every predicted result has been seen.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fd_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == fd_pkg::CFG_MAX_FRAME_LENGTH) lim_len = val[23:0];
    else if (idx == fd_pkg::CFG_MAX_SEEK_MODE) lim_seek = val[7:0];
    @(posedge clk);
  endtask

  // Upper bits carry junk so that the register width masking is exercised.
  task automatic set_limits(input logic [23:0] len_max, input logic [7:0] seek_max);
    wait_drained();
    write_reg(fd_pkg::CFG_MAX_FRAME_LENGTH, {8'($urandom()), len_max});
    write_reg(fd_pkg::CFG_MAX_SEEK_MODE, {24'($urandom()), seek_max});
  endtask

  task automatic send_descriptor(input logic [31:0] len, input logic [31:0] chan,
                                 input logic [63:0] off, input logic [31:0] seek);
    logic [8*fd_pkg::HDR_BYTES-1:0] d;
    d = {len, chan, off, seek};
    for (int i = 0; i < fd_pkg::HDR_BYTES; i++)
      send_byte(d[8*fd_pkg::HDR_BYTES-1 - 8*i -: 8]);
  endtask

  task automatic send_frame(input logic [31:0] len, input logic [31:0] chan,
                            input logic [63:0] off, input logic [31:0] seek);
    send_descriptor(len, chan, off, seek);
    for (int unsigned n = 0; n < len; n++) send_byte(8'($urandom()));
  endtask

  // A frame that passes the checks under the current limits.
  task automatic send_random_frame();
    logic [31:0] len;
    logic [31:0] chan;
    logic [31:0] seek;
    logic [63:0] off;
    int unsigned r;
    int unsigned top;
    r   = $urandom_range(0, 99);
    top = (lim_len < 24) ? 32'(lim_len) : 24;
    if (lim_len == 0 || r < 8) len = 0;
    else if (r < 16) len = 1;
    else if (r < 24 && lim_len <= 64) len = 32'(lim_len);
    else len = $urandom_range(1, top);
    chan = $urandom();
    if ($urandom_range(0, 3) == 0) chan = fd_pkg::PACKET_CHANNEL;
    else if (chan == fd_pkg::PACKET_CHANNEL) chan = 32'hFFFF_FFFE;
    if (chan == fd_pkg::PACKET_CHANNEL) seek = $urandom();
    else if ($urandom_range(0, 4) == 0) seek = 32'(lim_seek);
    else seek = $urandom_range(0, lim_seek);
    off = {$urandom(), $urandom()};
    send_frame(len, chan, off, seek);
  endtask

  task automatic test_directed();
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    // Single-byte data frame with the seek mode at its limit.
    send_frame(1, 32'h0, 64'h7FFF_FFFF_FFFF_FFFF, 32'd3);
    // Packet frame: the seek mode is not checked and the offset never shows.
    send_frame(2, fd_pkg::PACKET_CHANNEL, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF);
    // Zero-length frames end with their descriptor.
    send_frame(0, 32'h1234_5678, 64'h1, 32'd0);
    send_frame(0, fd_pkg::PACKET_CHANNEL, '0, 32'hDEAD_BEEF);
    // Payload extremes; the channel is one bit away from the packet marker.
    send_descriptor(4, 32'hFFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    wait_drained();
    sink_stalls = 1'b1;
    send_frame(6, 32'h8000_0001, 64'h0123_4567_89AB_CDEF, 32'd2);
    send_frame(3, fd_pkg::PACKET_CHANNEL, 64'h5A5A_5A5A_A5A5_A5A5, 32'd7);
  endtask

  task automatic test_config_limits();
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    // Tightest limits: only zero-length frames get through.
    set_limits('0, '0);
    send_frame(0, 32'h0000_0010, 64'h2, 32'd0);
    send_frame(0, fd_pkg::PACKET_CHANNEL, 64'h3, 32'hFFFF_FFFF);
    send_frame(0, 32'h7FFF_FFFF, '1, 32'd0);
    // A frame that sits exactly on both limits, then a packet frame with a seek mode above the limit.
    set_limits(24'd37, SEEK_LIMIT_MAX);
    send_frame(37, 32'h0, 64'hFEDC_BA98_7654_3210, 32'd255);
    send_frame(36, fd_pkg::PACKET_CHANNEL, '0, 32'h0000_0100);
    // A write to an index outside the register list changes nothing.
    wait_drained();
    write_reg(CFG_UNUSED, $urandom());
    send_frame(2, 32'h0000_0001, 64'h1, 32'd255);
    set_limits(LEN_LIMIT_MAX, '0);
    send_frame(5, 32'hCAFE_0000, 64'h8000_0000_0000_0001, 32'd0);
  endtask

  task automatic test_random_stream();
    int unsigned start;
    int unsigned frames;
    int unsigned pick;
    logic [23:0] len_max;
    logic [7:0]  seek_max;
    start  = bytes_sent;
    frames = 0;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if (frames % 12 == 0) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) len_max = '0;
        else if (pick < 3) len_max = LEN_LIMIT_MAX;
        else if (pick < 7) len_max = 24'($urandom_range(1, 40));
        else len_max = 24'($urandom());
        pick = $urandom_range(0, 3);
        if (pick == 0) seek_max = '0;
        else if (pick == 1) seek_max = SEEK_LIMIT_MAX;
        else seek_max = 8'($urandom());
        set_limits(len_max, seek_max);
      end
      // Idling changes every few frames; sometimes neither side idles.
      if (frames % 4 == 0) begin
        src_gaps    = ($urandom_range(0, 3) != 0);
        sink_stalls = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 9) == 0) wait_drained();
      send_random_frame();
      frames++;
    end
  endtask

  // A failed check kills the stream for good, so this runs last.
  task automatic test_dead_stream();
    int unsigned kind;
    logic [31:0] len;
    logic [31:0] chan;
    logic [31:0] seek;
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    wait_drained();
    kind = $urandom_range(0, 2);
    chan = $urandom() & 32'h7FFF_FFFF;
    seek = '0;
    len  = ($urandom_range(0, 1) == 0) ? 32'(lim_len) + 32'd1 : 32'hFFFF_FFFF;
    if (kind == 0 && $urandom_range(0, 1) == 0) chan = fd_pkg::PACKET_CHANNEL;
    if (kind != 0)
      seek = ($urandom_range(0, 1) == 0) ? 32'(lim_seek) + 32'd1 : 32'hFFFF_FFFF;
    // A bad seek alone needs a length within the limit.
    if (kind == 1) len = (lim_len < 8) ? 32'(lim_len) : $urandom_range(0, 8);
    send_descriptor(len, chan, {$urandom(), $urandom()}, seek);
    for (int i = 0; i < 40; i++) send_byte(8'($urandom()));
    set_limits(LEN_LIMIT_MAX, SEEK_LIMIT_MAX);
    send_frame(3, 32'h0, 64'h0, 32'd0);
  endtask

  initial begin
    reset_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_limits();
    test_random_stream();
    test_dead_stream();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/fd_pkg.sv
hw/rtl/fd_cfg.sv
hw/rtl/fd_parse.sv
hw/rtl/frame_deframer_unit.sv
hw/rtl/fd_checker.sv
verif/tb_top.sv
